@@ hw/rtl/icy_metadata_stream_deframer_core_defines.svh @@
// assertion macros for the icy metadata deframer checker
// expects clk_i and rst_ni in the scope of use
`ifndef ICY_METADATA_STREAM_DEFRAMER_CORE_DEFINES_SVH
`define ICY_METADATA_STREAM_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication
`define ICY_DFR_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("deframer check failed");

// next-cycle implication
`define ICY_DFR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("deframer check failed");

`endif

@@ hw/rtl/icy_dfr_pkg.sv @@
// shared types and constants of the icy metadata deframer
// no dependencies
package icy_dfr_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned LEN_W          = 16;
  localparam int unsigned META_REM_W     = 12;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned PHASE_W        = 2;
  // each length unit stands for 16 metadata bytes
  localparam int unsigned META_UNIT_SHIFT = 4;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_AUDIO = 2'd0;
  localparam logic [PHASE_W-1:0] PH_LEN   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_BODY  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_META_EN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_EMPTY = 2'd2;

  // word kinds
  localparam logic KIND_AUDIO = 1'b0;
  localparam logic KIND_META  = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              kind;
    logic              chunk_last;
  } word_t;

  typedef struct packed {
    logic [LEN_W-1:0] chunk_len;
    logic             meta_en;
    logic             drop_empty;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0]    phase;
    logic [META_REM_W-1:0] meta_rem;
  } meta_state_t;

endpackage

@@ hw/rtl/icy_dfr_if.sv @@
// stream and configuration channel interfaces of the icy metadata deframer
// depends on icy_dfr_pkg
interface icy_dfr_in_if;
  import icy_dfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface icy_dfr_out_if;
  import icy_dfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              kind;
  logic              chunk_last;
  modport source (output valid, output out_byte, output kind, output chunk_last, input ready);
  modport sink   (input valid, input out_byte, input kind, input chunk_last, output ready);
endinterface

interface icy_dfr_cfg_if;
  import icy_dfr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/icy_dfr_step.sv @@
// next-state and result logic for one stream byte
// depends on icy_dfr_pkg
module icy_dfr_step #(
  parameter int unsigned COUNT_W = 16
) (
  input  logic [icy_dfr_pkg::BYTE_W-1:0] byte_i,
  input  icy_dfr_pkg::cfg_t              cfg_i,
  input  icy_dfr_pkg::meta_state_t       meta_q_i,
  input  logic [COUNT_W-1:0]             count_q_i,
  output icy_dfr_pkg::meta_state_t       meta_d_o,
  output logic [COUNT_W-1:0]             count_d_o,
  output logic                           res_valid_o,
  output icy_dfr_pkg::word_t             res_o
);
  import icy_dfr_pkg::*;

  // compare width covers both the 16-bit length and the counter plus carry
  localparam int unsigned CMP_W = (COUNT_W + 1 > LEN_W) ? COUNT_W + 1 : LEN_W;

  logic [PHASE_W-1:0]    phase_eff;
  logic [CMP_W-1:0]      len_ext;
  logic [CMP_W-1:0]      next_ext;
  logic [META_REM_W-1:0] rem_new;

  always_comb begin
    // metadata off or unused code falls back to audio
    phase_eff = (!cfg_i.meta_en || meta_q_i.phase == PH_BODY + 2'd1) ? PH_AUDIO
                                                                     : meta_q_i.phase;
    len_ext   = (cfg_i.chunk_len == '0) ? CMP_W'(1) : CMP_W'(cfg_i.chunk_len);
    next_ext  = CMP_W'(count_q_i) + CMP_W'(1);
    rem_new   = META_REM_W'({{(META_REM_W - BYTE_W){1'b0}}, byte_i} << META_UNIT_SHIFT);

    meta_d_o          = meta_q_i;
    meta_d_o.phase    = phase_eff;
    count_d_o         = count_q_i;
    res_valid_o       = 1'b1;
    res_o.out_byte    = byte_i;
    res_o.kind        = KIND_META;
    res_o.chunk_last  = 1'b0;

    unique case (phase_eff)
      PH_LEN: begin
        if (byte_i == '0) begin
          meta_d_o.phase    = PH_AUDIO;
          meta_d_o.meta_rem = '0;
          res_valid_o       = !cfg_i.drop_empty;
          res_o.chunk_last  = 1'b1;
        end else begin
          meta_d_o.phase    = PH_BODY;
          meta_d_o.meta_rem = rem_new;
        end
      end
      PH_BODY: begin
        if (meta_q_i.meta_rem <= META_REM_W'(1)) begin
          meta_d_o.phase    = PH_AUDIO;
          meta_d_o.meta_rem = '0;
          res_o.chunk_last  = 1'b1;
        end else begin
          meta_d_o.meta_rem = meta_q_i.meta_rem - META_REM_W'(1);
        end
      end
      default: begin
        res_o.kind = KIND_AUDIO;
        if (next_ext >= len_ext) begin
          count_d_o        = '0;
          res_o.chunk_last = 1'b1;
          if (cfg_i.meta_en) begin
            meta_d_o.phase = PH_LEN;
          end
        end else begin
          count_d_o = next_ext[COUNT_W-1:0];
        end
      end
    endcase
  end

endmodule

@@ hw/rtl/icy_metadata_stream_deframer_core.sv @@
// icy metadata deframer: splits a byte stream into tagged audio and metadata words
// one byte in per cycle when the output side keeps up; a byte held in the input
// register moves into the result register once the result slot is free. the phase
// and counter update in icy_dfr_step is combinational, so a steady stream moves at
// one word per clock while the output keeps up. when metadata is
// enabled each audio chunk is followed by a length byte and 16 times that many
// metadata bytes; an empty block may be dropped, in which case no word comes out
// for that length byte. configuration writes are taken in every cycle and should
// only be issued while no byte is in flight. depends on icy_dfr_pkg, icy_dfr_if
// and icy_dfr_step.
module icy_metadata_stream_deframer_core #(
  parameter int unsigned CHUNK_COUNT_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  icy_dfr_in_if.sink    in_i,
  icy_dfr_out_if.source out_o,
  icy_dfr_cfg_if.sink   cfg_i
);
  import icy_dfr_pkg::*;

  // configuration registers
  cfg_t cfg_q, cfg_d;

  // input register
  logic              s1_valid_q, s1_valid_d;
  logic [BYTE_W-1:0] s1_byte_q;

  // deframer state
  meta_state_t                  meta_q, meta_d;
  logic [CHUNK_COUNT_WIDTH-1:0] count_q, count_d;

  // result register
  logic  out_valid_q, out_valid_d;
  word_t out_word_q;

  logic  in_acc;
  logic  out_free;
  logic  adv;
  logic  res_valid;
  word_t res_word;

  // result slot frees when empty or being taken this cycle
  assign out_free = !out_valid_q || out_o.ready;
  assign adv      = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_acc   = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_word_q.out_byte;
  assign out_o.kind       = out_word_q.kind;
  assign out_o.chunk_last = out_word_q.chunk_last;

  icy_dfr_step #(
    .COUNT_W (CHUNK_COUNT_WIDTH)
  ) u_step (
    .byte_i      (s1_byte_q),
    .cfg_i       (cfg_q),
    .meta_q_i    (meta_q),
    .count_q_i   (count_q),
    .meta_d_o    (meta_d),
    .count_d_o   (count_d),
    .res_valid_o (res_valid),
    .res_o       (res_word)
  );

  // register writes, index beyond the list is ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_CHUNK_LEN:  cfg_d.chunk_len  = cfg_i.data[LEN_W-1:0];
        REG_META_EN:    cfg_d.meta_en    = cfg_i.data[0];
        REG_DROP_EMPTY: cfg_d.drop_empty = cfg_i.data[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // a dropped empty block leaves the result slot empty
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = res_valid;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chunk_len  <= LEN_W'(4000);
      cfg_q.meta_en    <= 1'b0;
      cfg_q.drop_empty <= 1'b1;
      s1_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      meta_q.phase     <= PH_AUDIO;
      meta_q.meta_rem  <= '0;
      count_q          <= '0;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      // state moves only when the byte in the input register is processed
      if (adv) begin
        meta_q  <= meta_d;
        count_q <= count_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= in_i.stream_byte;
    end
    if (adv && res_valid) begin
      out_word_q <= res_word;
    end
  end

endmodule

@@ hw/rtl/icy_dfr_checker.sv @@
// port-level checks for the icy metadata deframer, bound to the top level
// depends on icy_metadata_stream_deframer_core_defines.svh
`include "icy_metadata_stream_deframer_core_defines.svh"

module icy_dfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_kind_i,
  input logic       out_last_i
);

  // a stalled word holds still
  `ICY_DFR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_byte_i) && $stable(out_kind_i) && $stable(out_last_i))

  // input back-pressure only comes from a stalled output
  `ICY_DFR_ASSERT_IMPL(a_stall_cause, !in_ready_i, out_valid_i && !out_ready_i)

  // a new word into an empty slot comes from a byte taken at the input and passed through the input register
  `ICY_DFR_ASSERT_IMPL(a_word_origin, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2))

endmodule

bind icy_metadata_stream_deframer_core icy_dfr_checker u_icy_dfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_kind_i  (out_o.kind),
  .out_last_i  (out_o.chunk_last)
);
